/* sv/qpam_pkg.sv */
`timescale 1ns / 1ps

package qpam_pkg;

  localparam int ROTOR_COUNT = 4;
  localparam int SIGNAL_BITS = 32;
  localparam int SIG_W       = SIGNAL_BITS;
  localparam int EXT_W       = SIG_W + 4;   // headroom for three-term sums
  localparam int IN_W        = 32;          // width of the signal fields on the ports
  localparam int OUT_W       = 32;
  localparam int AXIS_COUNT  = 4;
  localparam int AXIS_W      = 2;
  localparam int ROTOR_W     = 2;
  localparam int STICK_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int GAIN_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_ALT   = 2'd0,
    AXIS_ROLL  = 2'd1,
    AXIS_PITCH = 2'd2,
    AXIS_YAW   = 2'd3
  } axis_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ALT = 3'd4;

  localparam logic [30:0] HOVER_RST    = 31'd0;
  localparam logic [31:0] STEP_RST     = 32'd4294967;
  localparam logic [30:0] INV_STEP_RST = 31'd65536000;
  localparam logic [14:0] DEADBAND_RST = 15'd6554;

  typedef logic signed [SIG_W-1:0] sig_t;

  typedef struct packed {
    logic [30:0] hover_thrust;
    logic [31:0] step_time;
    logic [30:0] inverse_step_time;
    logic [14:0] deadband;
  } qpam_cfg_t;

  typedef struct packed {
    logic load;
    sig_t value;
  } qpam_alt_load_t;

  // one classified axis sample
  typedef struct packed {
    axis_e                     axis;
    logic signed [STICK_W-1:0] stick;    // after deadband
    sig_t                      angle;
    sig_t                      rate;
    sig_t                      lat_ref;  // roll/pitch reference, sign already applied
  } qpam_item_t;

  typedef struct packed {
    logic                       valid;
    sig_t [AXIS_COUNT-1:0]      effort;
  } qpam_mix_t;

  // PD gains, Q0.32
  localparam logic [GAIN_W-1:0] P_GAIN [AXIS_COUNT] =
    '{32'd429496730, 32'd12884902, 32'd12884902, 32'd85899};
  localparam logic [GAIN_W-1:0] D_GAIN [AXIS_COUNT] =
    '{32'd214748365, 32'd8589935, 32'd8589935, 32'd42950};

  // bit k set: axis k enters rotor r with a minus sign
  localparam logic [AXIS_COUNT-1:0] MIX_NEG [ROTOR_COUNT] =
    '{4'b1110, 4'b0100, 4'b1000, 4'b0010};
  localparam logic [ROTOR_COUNT-1:0] TORQUE_NEG = 4'b0101;

  // x / 10 == (x * RECIP10) >> 27 for x < 2^26
  localparam logic [GAIN_W-1:0] RECIP10       = 32'd13421773;
  localparam int                RECIP10_SHIFT = 27;
  localparam int                YAW_GAIN      = 42;   // 2.1 * 2 (Q1.15 -> Q16.16) * 10, /10 later
  localparam int                YAW_ROUND     = 5;

  function automatic logic signed [EXT_W-1:0] ext(input sig_t v);
    return EXT_W'(v);
  endfunction

  function automatic sig_t sat_ext(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = {{(EXT_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
    lo = {{(EXT_W-SIG_W+1){1'b1}}, {(SIG_W-1){1'b0}}};
    if (v > hi) return sig_t'(hi);
    if (v < lo) return sig_t'(lo);
    return sig_t'(v);
  endfunction

  function automatic sig_t sat_in(input logic signed [IN_W-1:0] v);
    logic signed [IN_W+SIG_W-1:0] w;
    logic signed [IN_W+SIG_W-1:0] hi;
    logic signed [IN_W+SIG_W-1:0] lo;
    w  = (IN_W+SIG_W)'(v);
    hi = {{(IN_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
    lo = {{(IN_W+1){1'b1}}, {(SIG_W-1){1'b0}}};
    if (w > hi) return sig_t'(hi);
    if (w < lo) return sig_t'(lo);
    return sig_t'(w);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input sig_t v);
    logic signed [SIG_W+OUT_W-1:0] w;
    logic signed [SIG_W+OUT_W-1:0] hi;
    logic signed [SIG_W+OUT_W-1:0] lo;
    w  = (SIG_W+OUT_W)'(v);
    hi = {{(SIG_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = {{(SIG_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    if (w > hi) return OUT_W'(hi);
    if (w < lo) return OUT_W'(lo);
    return OUT_W'(w);
  endfunction

endpackage

/* sv/qpam_if.sv */
`timescale 1ns / 1ps

interface qpam_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [qpam_pkg::AXIS_W-1:0]             axis;
  logic signed [qpam_pkg::STICK_W-1:0]     stick;
  logic signed [qpam_pkg::IN_W-1:0]        angle;
  logic signed [qpam_pkg::IN_W-1:0]        rate;
  logic signed [qpam_pkg::IN_W-1:0]        lateral_velocity;
  logic signed [qpam_pkg::IN_W-1:0]        lateral_acceleration;

  modport source (output valid, axis, stick, angle, rate, lateral_velocity,
                  lateral_acceleration, input ready);
  modport sink   (input valid, axis, stick, angle, rate, lateral_velocity,
                  lateral_acceleration, output ready);
endinterface

interface qpam_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [qpam_pkg::ROTOR_W-1:0]            rotor;
  logic signed [qpam_pkg::OUT_W-1:0]       force_res;
  logic signed [qpam_pkg::OUT_W-1:0]       torque;
  logic                                    last;

  modport source (output valid, rotor, force_res, torque, last, input ready);
  modport sink   (input valid, rotor, force_res, torque, last, output ready);
endinterface

interface qpam_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [qpam_pkg::CFG_IDX_W-1:0]          index;
  logic [qpam_pkg::CFG_DATA_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/qpam_front.sv */
`timescale 1ns / 1ps

// Input classification: deadband, input saturation, lateral reference.
module qpam_front (
  qpam_in_if.sink              in_chan_i,
  input  qpam_pkg::qpam_cfg_t  cfg_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output qpam_pkg::qpam_item_t item_o
);

  logic signed [qpam_pkg::STICK_W:0]     stick_x;
  logic [qpam_pkg::STICK_W:0]            stick_mag;
  logic signed [qpam_pkg::STICK_W-1:0]   stick_db;
  logic signed [qpam_pkg::EXT_W-1:0]     lat_sum;
  qpam_pkg::sig_t                        lat_ref;

  assign in_chan_i.ready = !q_full_i;
  assign push_o          = in_chan_i.valid && !q_full_i;

  always_comb begin
    stick_x   = (qpam_pkg::STICK_W+1)'(in_chan_i.stick);
    stick_mag = stick_x[qpam_pkg::STICK_W] ? 17'(-stick_x) : 17'(stick_x);
    stick_db  = (stick_mag < {2'b00, cfg_i.deadband}) ? '0 : in_chan_i.stick;

    // -8*stick - v - a, one saturation at the end
    lat_sum = -(qpam_pkg::EXT_W'(stick_db) <<< 3)
              - qpam_pkg::ext(qpam_pkg::sat_in(in_chan_i.lateral_velocity))
              - qpam_pkg::ext(qpam_pkg::sat_in(in_chan_i.lateral_acceleration));
    lat_ref = qpam_pkg::sat_ext(lat_sum);
    if (qpam_pkg::axis_e'(in_chan_i.axis) == qpam_pkg::AXIS_ROLL) begin
      lat_ref = qpam_pkg::sat_ext(-qpam_pkg::ext(lat_ref));
    end

    item_o.axis    = qpam_pkg::axis_e'(in_chan_i.axis);
    item_o.stick   = stick_db;
    item_o.angle   = qpam_pkg::sat_in(in_chan_i.angle);
    item_o.rate    = qpam_pkg::sat_in(in_chan_i.rate);
    item_o.lat_ref = lat_ref;
  end

endmodule

/* sv/qpam_queue.sv */
`timescale 1ns / 1ps

// Small register FIFO between front and back.
module qpam_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qpam_pkg::qpam_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output qpam_pkg::qpam_item_t pop_item_o
);

  localparam int PTR_W = (qpam_pkg::QUEUE_DEPTH > 1) ? $clog2(qpam_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(qpam_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(qpam_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(qpam_pkg::QUEUE_DEPTH - 1);

  qpam_pkg::qpam_item_t entry_q [qpam_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q;

  assign full_o     = (cnt_q == DEPTH_C);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* sv/qpam_back.sv */
`timescale 1ns / 1ps

// Control law sequencer around one shared magnitude multiplier.
module qpam_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qpam_pkg::qpam_cfg_t      cfg_i,
  input  qpam_pkg::qpam_alt_load_t alt_load_i,
  input  logic                     q_valid_i,
  input  qpam_pkg::qpam_item_t     q_item_i,
  output logic                     q_pop_o,
  output qpam_pkg::qpam_mix_t      mix_o,
  input  logic                     mix_ready_i
);

  localparam int SIG_W  = qpam_pkg::SIG_W;
  localparam int PROD_W = SIG_W + qpam_pkg::GAIN_W;
  localparam int QW     = PROD_W - 15;
  localparam logic [PROD_W:0] RND32 = (PROD_W+1)'(1) << 31;
  localparam logic [PROD_W:0] RND16 = (PROD_W+1)'(1) << 15;

  typedef enum logic [2:0] {
    B_IDLE, B_SETUP, B_MUL, B_POST, B_DSET, B_ERR, B_HAND
  } bstate_e;

  typedef enum logic [2:0] {
    PH_ALT, PH_YREF, PH_DER, PH_P, PH_D
  } phase_e;

  bstate_e                              state_q;
  phase_e                               phase_q;
  qpam_pkg::qpam_item_t                 item_q;
  logic [SIG_W-1:0]                     opa_q;
  logic [qpam_pkg::GAIN_W-1:0]          opb_q;
  logic                                 neg_q;
  logic [PROD_W-1:0]                    prod_q;
  qpam_pkg::sig_t                       ref_q, damp_q, term_p_q;
  qpam_pkg::sig_t                       target_q, prev_q;
  qpam_pkg::sig_t [qpam_pkg::AXIS_COUNT-1:0] effort_q;

  // magnitude + sign back to a saturated signal, half away from zero done before
  function automatic qpam_pkg::sig_t mag_to_sig(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim;
    logic [QW-1:0] m;
    lim = QW'(1) << (SIG_W - 1);
    if (neg) begin
      m = (q > lim) ? lim : q;
      m = ~m + 1'b1;
    end else begin
      m = (q > lim - 1'b1) ? lim - 1'b1 : q;
    end
    return m[SIG_W-1:0];
  endfunction

  function automatic logic [SIG_W-1:0] mag(input qpam_pkg::sig_t v);
    logic [SIG_W-1:0] u;
    u = v;
    return u[SIG_W-1] ? (~u + 1'b1) : u;
  endfunction

  logic [PROD_W-1:0]                  mul_full;
  logic [PROD_W:0]                    sum32, sum16;
  logic [PROD_W-1:0]                  div_shift;
  qpam_pkg::sig_t                     mul_res, der_res, yref_res, alt_res, diff;
  qpam_pkg::sig_t                     err, damp;
  logic signed [qpam_pkg::STICK_W:0]  stick_x;
  logic [qpam_pkg::STICK_W:0]         stick_mag;
  logic signed [21:0]                 yaw_p;
  logic [21:0]                        yaw_mag;

  always_comb begin
    mul_full  = PROD_W'(opa_q) * PROD_W'(opb_q);
    sum32     = {1'b0, prod_q} + RND32;
    sum16     = {1'b0, prod_q} + RND16;
    div_shift = prod_q >> qpam_pkg::RECIP10_SHIFT;
    mul_res   = mag_to_sig(QW'(sum32 >> 32), neg_q);
    der_res   = mag_to_sig(QW'(sum16 >> 16), neg_q);
    yref_res  = mag_to_sig(div_shift[QW-1:0], !neg_q);
    alt_res   = qpam_pkg::sat_ext(qpam_pkg::ext(target_q) + qpam_pkg::ext(mul_res));

    stick_x   = (qpam_pkg::STICK_W+1)'(item_q.stick);
    stick_mag = stick_x[qpam_pkg::STICK_W] ? 17'(-stick_x) : 17'(stick_x);
    yaw_p     = 22'(item_q.stick) * 22'(qpam_pkg::YAW_GAIN);
    yaw_mag   = (yaw_p < 0 ? 22'(-yaw_p) : 22'(yaw_p)) + 22'(qpam_pkg::YAW_ROUND);

    diff = qpam_pkg::sat_ext(qpam_pkg::ext(item_q.rate) - qpam_pkg::ext(prev_q));
    err  = qpam_pkg::sat_ext(qpam_pkg::ext(ref_q) -
             qpam_pkg::ext(item_q.axis == qpam_pkg::AXIS_YAW ? item_q.rate : item_q.angle));
    damp = (item_q.axis == qpam_pkg::AXIS_YAW) ? damp_q
         : qpam_pkg::sat_ext(-qpam_pkg::ext(item_q.rate));
  end

  assign q_pop_o      = (state_q == B_IDLE) && q_valid_i;
  assign mix_o.valid  = (state_q == B_HAND);
  assign mix_o.effort = effort_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      target_q <= '0;
      prev_q   <= '0;
      effort_q <= '0;
    end else begin
      if (alt_load_i.load) begin
        target_q <= alt_load_i.value;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            item_q  <= q_item_i;
            state_q <= B_SETUP;
          end
        end
        B_SETUP: begin
          unique case (item_q.axis)
            qpam_pkg::AXIS_ALT: begin
              opa_q   <= SIG_W'(stick_mag);
              opb_q   <= cfg_i.step_time;
              neg_q   <= (item_q.stick > 0);    // target moves against the stick
              phase_q <= PH_ALT;
              state_q <= B_MUL;
            end
            qpam_pkg::AXIS_ROLL, qpam_pkg::AXIS_PITCH: begin
              ref_q   <= item_q.lat_ref;
              state_q <= B_ERR;
            end
            qpam_pkg::AXIS_YAW: begin
              opa_q   <= SIG_W'(yaw_mag);
              opb_q   <= qpam_pkg::RECIP10;
              neg_q   <= (yaw_p < 0);
              phase_q <= PH_YREF;
              state_q <= B_MUL;
            end
          endcase
        end
        B_MUL: begin
          prod_q  <= mul_full;
          state_q <= B_POST;
        end
        B_POST: begin
          unique case (phase_q)
            PH_ALT: begin
              target_q <= alt_res;
              ref_q    <= alt_res;
              state_q  <= B_ERR;
            end
            PH_YREF: begin
              ref_q   <= yref_res;
              state_q <= B_DSET;
            end
            PH_DER: begin
              damp_q  <= qpam_pkg::sat_ext(-qpam_pkg::ext(der_res));
              prev_q  <= item_q.rate;
              state_q <= B_ERR;
            end
            PH_P: begin
              term_p_q <= mul_res;
              opa_q    <= mag(damp_q);
              opb_q    <= qpam_pkg::D_GAIN[item_q.axis];
              neg_q    <= damp_q[SIG_W-1];
              phase_q  <= PH_D;
              state_q  <= B_MUL;
            end
            PH_D: begin
              effort_q[item_q.axis] <=
                qpam_pkg::sat_ext(qpam_pkg::ext(term_p_q) + qpam_pkg::ext(mul_res));
              state_q <= (item_q.axis == qpam_pkg::AXIS_YAW) ? B_HAND : B_IDLE;
            end
            default: state_q <= B_IDLE;
          endcase
        end
        B_DSET: begin
          opa_q   <= mag(diff);
          opb_q   <= {1'b0, cfg_i.inverse_step_time};
          neg_q   <= diff[SIG_W-1];
          phase_q <= PH_DER;
          state_q <= B_MUL;
        end
        B_ERR: begin
          damp_q  <= damp;
          opa_q   <= mag(err);
          opb_q   <= qpam_pkg::P_GAIN[item_q.axis];
          neg_q   <= err[SIG_W-1];
          phase_q <= PH_P;
          state_q <= B_MUL;
        end
        B_HAND: begin
          if (mix_ready_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

/* sv/qpam_mixer.sv */
`timescale 1ns / 1ps

// Rotor mixer: one signed accumulate per cycle in M_ACC, registered output; M_OUT waits for room.
module qpam_mixer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qpam_pkg::qpam_cfg_t cfg_i,
  input  qpam_pkg::qpam_mix_t mix_i,
  output logic                mix_ready_o,
  qpam_out_if.source          out_chan_o
);

  typedef enum logic [1:0] {M_IDLE, M_ACC, M_OUT} mstate_e;

  localparam logic [qpam_pkg::ROTOR_W-1:0] LAST_ROTOR = 2'(qpam_pkg::ROTOR_COUNT - 1);
  localparam logic [qpam_pkg::AXIS_W-1:0]  LAST_AXIS  = 2'(qpam_pkg::AXIS_COUNT - 1);

  mstate_e                                    state_q;
  qpam_pkg::sig_t [qpam_pkg::AXIS_COUNT-1:0]  eff_q;
  logic [qpam_pkg::ROTOR_W-1:0]               r_q;
  logic [qpam_pkg::AXIS_W-1:0]                k_q;
  qpam_pkg::sig_t                             acc_q;
  qpam_pkg::sig_t                             hover;
  qpam_pkg::sig_t                             acc_d;
  qpam_pkg::sig_t                             torque;
  logic                                       ov_q;
  logic [qpam_pkg::ROTOR_W-1:0]               rotor_q;
  logic signed [qpam_pkg::OUT_W-1:0]          force_q, torque_q;
  logic                                       last_q;

  always_comb begin
    hover  = qpam_pkg::sat_in(qpam_pkg::IN_W'(cfg_i.hover_thrust));
    acc_d  = qpam_pkg::MIX_NEG[r_q][k_q]
           ? qpam_pkg::sat_ext(qpam_pkg::ext(acc_q) - qpam_pkg::ext(eff_q[k_q]))
           : qpam_pkg::sat_ext(qpam_pkg::ext(acc_q) + qpam_pkg::ext(eff_q[k_q]));
    torque = qpam_pkg::TORQUE_NEG[r_q] ? qpam_pkg::sat_ext(-qpam_pkg::ext(acc_q)) : acc_q;
  end

  assign mix_ready_o          = (state_q == M_IDLE);
  assign out_chan_o.valid     = ov_q;
  assign out_chan_o.rotor     = rotor_q;
  assign out_chan_o.force_res = force_q;
  assign out_chan_o.torque    = torque_q;
  assign out_chan_o.last      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      ov_q    <= 1'b0;
    end else begin
      // M_OUT refills the output register itself once it drains
      if (out_chan_o.ready && (state_q != M_OUT)) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        M_IDLE: begin
          if (mix_i.valid) begin
            eff_q   <= mix_i.effort;
            acc_q   <= hover;
            r_q     <= '0;
            k_q     <= '0;
            state_q <= M_ACC;
          end
        end
        M_ACC: begin
          acc_q <= acc_d;
          k_q   <= k_q + 1'b1;
          if (k_q == LAST_AXIS) begin
            state_q <= M_OUT;
          end
        end
        M_OUT: begin
          if (!ov_q || out_chan_o.ready) begin
            ov_q     <= 1'b1;
            rotor_q  <= r_q;
            force_q  <= qpam_pkg::sat_out(acc_q);
            torque_q <= qpam_pkg::sat_out(torque);
            last_q   <= (r_q == LAST_ROTOR);
            if (r_q == LAST_ROTOR) begin
              state_q <= M_IDLE;
            end else begin
              r_q     <= r_q + 1'b1;
              k_q     <= '0;
              acc_q   <= hover;
              state_q <= M_ACC;
            end
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

endmodule

/* sv/quadrotor_pd_attitude_mixer_top.sv */
`timescale 1ns / 1ps

// Channel      Dir  Handshake    Payload
// in_chan_i    in   valid/ready  axis, stick, angle, rate, lateral_velocity,
//                                lateral_acceleration
// out_chan_o   out  valid/ready  rotor, force_res, torque, last
// cfg_i        in   valid/ready  index (register number), data
//
// Steps: the control law sequencer pops an item and runs each product through
// the single shared multiplier as one setup, multiply and post step; a yaw item
// then waits in a hand-off step until the mixer takes it. The mixer builds each
// of the four rotor results with four accumulate steps and one output load.
// The two-entry queue takes items while the sequencer works, and the sequencer
// moves on to non-yaw items while the mixer and its output register wait on
// out_chan_o.ready; a yaw item waits in hand-off until the mixer is idle.
// Reset: asynchronous, active low; registers return to their defaults, axis
// efforts, previous yaw rate and the altitude target clear. cfg_i is always ready.
module quadrotor_pd_attitude_mixer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  qpam_in_if.sink     in_chan_i,
  qpam_out_if.source  out_chan_o,
  qpam_cfg_if.sink    cfg_i
);

  qpam_pkg::qpam_cfg_t      cfg_q;
  qpam_pkg::qpam_alt_load_t alt_load;
  qpam_pkg::qpam_item_t     front_item, queue_item;
  logic                     push, q_full, q_valid, q_pop;
  qpam_pkg::qpam_mix_t      mix;
  logic                     mix_ready;

  // register writes are to be issued only while the block is idle; the block itself does not enforce this
  assign cfg_i.ready    = 1'b1;
  assign alt_load.load  = cfg_i.valid && (cfg_i.index == qpam_pkg::CFG_START_ALT);
  assign alt_load.value = qpam_pkg::sat_in(cfg_i.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hover_thrust      <= qpam_pkg::HOVER_RST;
      cfg_q.step_time         <= qpam_pkg::STEP_RST;
      cfg_q.inverse_step_time <= qpam_pkg::INV_STEP_RST;
      cfg_q.deadband          <= qpam_pkg::DEADBAND_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        qpam_pkg::CFG_HOVER:    cfg_q.hover_thrust      <= cfg_i.data[30:0];
        qpam_pkg::CFG_STEP:     cfg_q.step_time         <= cfg_i.data;
        qpam_pkg::CFG_INV_STEP: cfg_q.inverse_step_time <= cfg_i.data[30:0];
        qpam_pkg::CFG_DEADBAND: cfg_q.deadband          <= cfg_i.data[14:0];
        default: ;  // start altitude goes to the sequencer, others ignored
      endcase
    end
  end

  qpam_front u_front (
    .in_chan_i (in_chan_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .item_o    (front_item)
  );

  qpam_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (queue_item)
  );

  qpam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .alt_load_i  (alt_load),
    .q_valid_i   (q_valid),
    .q_item_i    (queue_item),
    .q_pop_o     (q_pop),
    .mix_o       (mix),
    .mix_ready_i (mix_ready)
  );

  qpam_mixer u_mixer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mix_i       (mix),
    .mix_ready_o (mix_ready),
    .out_chan_o  (out_chan_o)
  );

endmodule

/* sv/qpam_checker.sv */
`timescale 1ns / 1ps

module qpam_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [qpam_pkg::ROTOR_W-1:0]         rotor_i,
  input logic signed [qpam_pkg::OUT_W-1:0]    force_i,
  input logic signed [qpam_pkg::OUT_W-1:0]    torque_i,
  input logic                                 last_i
);

  localparam logic signed [qpam_pkg::OUT_W-1:0] MIN_OUT =
    {1'b1, {(qpam_pkg::OUT_W-1){1'b0}}};
  localparam logic [qpam_pkg::ROTOR_W-1:0] LAST_ROTOR = 2'(qpam_pkg::ROTOR_COUNT - 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rotor_i) &&
    $stable(force_i) && $stable(torque_i) && $stable(last_i))
    else $error("result changed while stalled");

  // last marks the final rotor of a run
  a_last_rotor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (rotor_i == LAST_ROTOR)))
    else $error("last flag does not match rotor index");

  // reaction torque sign per rotor
  a_torque_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && force_i != MIN_OUT |->
    (rotor_i[0] ? (torque_i == force_i) : (torque_i == -force_i)))
    else $error("torque is not the signed copy of force");

  // nothing is pending right after reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result shown right after reset");

endmodule

bind quadrotor_pd_attitude_mixer_top qpam_checker u_qpam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .rotor_i     (out_chan_o.rotor),
  .force_i     (out_chan_o.force_res),
  .torque_i    (out_chan_o.torque),
  .last_i      (out_chan_o.last)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

// Bench for the PD attitude controller with its four-rotor mixer.
// Axis samples are queued by the stimulus process, handed to the DUT by a
// bursty driver, and scored against a cycle-free copy of the control law.
module testbench;

  // Bench timing
  localparam int SETTLE_CYCLES  = 100;   // lets queued items clear the sequencer and the mixer
  localparam int WATCHDOG_LIMIT = 3000;  // idle cycles before we give up
  localparam int LONG_HOLD      = 400;   // one long output back-pressure stretch
  localparam int LONG_HOLD_AT   = 32;    // rotor results seen before it starts

  localparam logic signed [qpam_pkg::IN_W-1:0]    SIG_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [qpam_pkg::IN_W-1:0]    SIG_MIN   = 32'sh8000_0000;
  localparam logic signed [qpam_pkg::STICK_W-1:0] STICK_MAX = 16'sh7FFF;
  localparam logic signed [qpam_pkg::STICK_W-1:0] STICK_MIN = 16'sh8000;

  // Register slots past the last mapped one; writes there must do nothing
  localparam logic [qpam_pkg::CFG_IDX_W-1:0] CFG_IDX_UNMAPPED =
    qpam_pkg::CFG_START_ALT + 3'd1;
  localparam logic [qpam_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP      = '1;

  // Control law gains, Q0.32
  localparam logic [31:0] KP_Q32 [qpam_pkg::AXIS_COUNT] = '{32'd429496730, 32'd12884902,
                                                            32'd12884902, 32'd85899};
  localparam logic [31:0] KD_Q32 [qpam_pkg::AXIS_COUNT] = '{32'd214748365, 32'd8589935,
                                                            32'd8589935, 32'd42950};
  localparam int          YAW_STICK_X10 = 42;  // 2.1 * 2 (Q1.15 -> Q16.16), x10
  // Mixer: bit k set means axis k is subtracted for that rotor
  localparam logic [qpam_pkg::AXIS_COUNT-1:0]  MIX_MINUS [qpam_pkg::ROTOR_COUNT] =
    '{4'b1110, 4'b0100, 4'b1000, 4'b0010};
  localparam logic [qpam_pkg::ROTOR_COUNT-1:0] SPIN_MINUS = 4'b0101;

  typedef struct packed {
    qpam_pkg::axis_e                     axis;
    logic signed [qpam_pkg::STICK_W-1:0] stick;
    logic signed [qpam_pkg::IN_W-1:0]    angle;
    logic signed [qpam_pkg::IN_W-1:0]    rate;
    logic signed [qpam_pkg::IN_W-1:0]    lat_vel;
    logic signed [qpam_pkg::IN_W-1:0]    lat_acc;
  } axis_sample_t;

  typedef struct packed {
    logic [qpam_pkg::ROTOR_W-1:0]      rotor;
    logic signed [qpam_pkg::OUT_W-1:0] thrust;
    logic signed [qpam_pkg::OUT_W-1:0] torque;
    logic                              last;
  } rotor_cmd_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  qpam_in_if  in_chan ();
  qpam_out_if out_chan ();
  qpam_cfg_if cfg_chan ();

  quadrotor_pd_attitude_mixer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_i      (cfg_chan)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the controller: registers, state, expected rotor commands
  // ---------------------------------------------------------------------
  logic [30:0]  hover_r;
  logic [31:0]  step_r;
  logic [30:0]  inv_step_r;
  logic [14:0]  deadband_r;
  longint       alt_target;
  longint       prev_yaw_rate;
  longint       axis_effort [qpam_pkg::AXIS_COUNT];

  rotor_cmd_t   rotor_cmd_q [$];     // commands still owed by the DUT
  axis_sample_t pending_q [$];       // samples not yet handed to the driver
  int           samples_queued   = 0;
  int           samples_accepted = 0;
  int           rotor_results    = 0;
  int           failures         = 0;

  function automatic longint clip_to(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint clip_signal(longint v);
    return clip_to(v, qpam_pkg::SIGNAL_BITS);
  endfunction

  // a * g / 2^sh, rounded half away from zero, saturated to the signal range
  function automatic longint scale_round(longint a, logic [31:0] g, int sh);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] lim;
    lim = 128'd1 << (qpam_pkg::SIGNAL_BITS - 1);
    mag = (a < 0) ? 128'(-a) : 128'(a);
    q   = (mag * g + (128'd1 << (sh - 1))) >> sh;
    if (q > lim) q = lim;
    if (a < 0) return clip_signal(-longint'(q));
    if (q == lim) q = lim - 1;
    return longint'(q);
  endfunction

  function automatic void reset_shadow();
    hover_r       = qpam_pkg::HOVER_RST;
    step_r        = qpam_pkg::STEP_RST;
    inv_step_r    = qpam_pkg::INV_STEP_RST;
    deadband_r    = qpam_pkg::DEADBAND_RST;
    alt_target    = 0;
    prev_yaw_rate = 0;
    for (int k = 0; k < qpam_pkg::AXIS_COUNT; k++) axis_effort[k] = 0;
  endfunction

  function automatic void shadow_reg_write(logic [qpam_pkg::CFG_IDX_W-1:0] idx,
                                           logic [qpam_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      qpam_pkg::CFG_HOVER:     hover_r    = data[30:0];
      qpam_pkg::CFG_STEP:      step_r     = data;
      qpam_pkg::CFG_INV_STEP:  inv_step_r = data[30:0];
      qpam_pkg::CFG_DEADBAND:  deadband_r = data[14:0];
      qpam_pkg::CFG_START_ALT: alt_target = clip_signal(longint'($signed(data)));
      default: ;
    endcase
  endfunction

  // One axis sample through the PD law; a yaw sample also runs the mixer
  // and owes four rotor commands.
  function automatic void run_control_law(axis_sample_t s);
    longint     stick;
    longint     angle;
    longint     rate;
    longint     vel;
    longint     acc;
    longint     mag;
    longint     target;
    longint     err;
    longint     damp;
    longint     yaw_cmd;
    longint     rounded;
    longint     deriv;
    longint     thrust;
    longint     spin;
    rotor_cmd_t cmd;
    stick = longint'($signed(s.stick));
    angle = clip_signal(longint'($signed(s.angle)));
    rate  = clip_signal(longint'($signed(s.rate)));
    vel   = clip_signal(longint'($signed(s.lat_vel)));
    acc   = clip_signal(longint'($signed(s.lat_acc)));
    mag   = (stick < 0) ? -stick : stick;
    if (mag < longint'(deadband_r)) stick = 0;

    if (s.axis == qpam_pkg::AXIS_YAW) begin
      // rate command -2.1 * stick, rounded half away from zero
      yaw_cmd = stick * YAW_STICK_X10;
      rounded = (((yaw_cmd < 0) ? -yaw_cmd : yaw_cmd) + 5) / 10;
      target  = clip_signal((yaw_cmd < 0) ? rounded : -rounded);
      deriv   = scale_round(clip_signal(rate - prev_yaw_rate), inv_step_r, 16);
      err     = clip_signal(target - rate);
      damp    = clip_signal(-deriv);
      axis_effort[qpam_pkg::AXIS_YAW] =
        clip_signal(scale_round(err, KP_Q32[qpam_pkg::AXIS_YAW], 32) +
                    scale_round(damp, KD_Q32[qpam_pkg::AXIS_YAW], 32));
      prev_yaw_rate = rate;

      for (int r = 0; r < qpam_pkg::ROTOR_COUNT; r++) begin
        thrust = longint'(hover_r);
        for (int k = 0; k < qpam_pkg::AXIS_COUNT; k++)
          thrust = clip_signal(MIX_MINUS[r][k] ? thrust - axis_effort[k]
                                               : thrust + axis_effort[k]);
        spin        = clip_signal(SPIN_MINUS[r] ? -thrust : thrust);
        cmd.rotor   = qpam_pkg::ROTOR_W'(r);
        cmd.thrust  = qpam_pkg::OUT_W'(clip_to(thrust, qpam_pkg::OUT_W));
        cmd.torque  = qpam_pkg::OUT_W'(clip_to(spin, qpam_pkg::OUT_W));
        cmd.last    = (r == qpam_pkg::ROTOR_COUNT - 1);
        rotor_cmd_q.push_back(cmd);
      end
    end else begin
      if (s.axis == qpam_pkg::AXIS_ALT) begin
        // altitude target integrates -0.5 * stick * period
        alt_target = clip_signal(alt_target + scale_round(-stick, step_r, 32));
        target     = alt_target;
      end else begin
        target = clip_signal(-8 * stick - vel - acc);
        if (s.axis == qpam_pkg::AXIS_ROLL) target = clip_signal(-target);
      end
      err  = clip_signal(target - angle);
      damp = clip_signal(-rate);
      axis_effort[s.axis] = clip_signal(scale_round(err, KP_Q32[s.axis], 32) +
                                        scale_round(damp, KD_Q32[s.axis], 32));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of samples from pending_q with random gaps between them.
  // The shadow model steps on the same edge the DUT takes the transaction.
  // ---------------------------------------------------------------------
  axis_sample_t in_flight;
  int           burst_left = 0;
  int           gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_chan.valid && in_chan.ready) begin
        run_control_law(in_flight);
        samples_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_flight = pending_q.pop_front();
          in_chan.axis                 <= in_flight.axis;
          in_chan.stick                <= in_flight.stick;
          in_chan.angle                <= in_flight.angle;
          in_chan.rate                 <= in_flight.rate;
          in_chan.lateral_velocity     <= in_flight.lat_vel;
          in_chan.lateral_acceleration <= in_flight.lat_acc;
          in_chan.valid                <= 1'b1;
          // one gap in four is zero, so some bursts run back to back
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver back-pressure: open, random and sparse stretches, plus one
  // long hold-off that lets the input queue fill and stall the sender.
  // ---------------------------------------------------------------------
  rx_mode_e rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       hold_left  = 0;
  bit       hold_done  = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (!hold_done && rotor_results >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_chan.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 60);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   out_chan.ready <= 1'b1;
          RX_RANDOM: out_chan.ready <= 1'($urandom_range(0, 1));
          default:   out_chan.ready <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every output transaction is scored against the oldest
  // expected rotor command.
  // ---------------------------------------------------------------------
  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    rotor_cmd_t want;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      rotor_results++;
      if (rotor_cmd_q.size() == 0) begin
        $display("%0t: unexpected rotor result, rotor %0d force_res %0d", $time,
                 out_chan.rotor, out_chan.force_res);
        failures++;
      end else begin
        want = rotor_cmd_q.pop_front();
        compare_field("rotor", want.rotor, out_chan.rotor);
        compare_field("force_res", want.thrust, out_chan.force_res);
        compare_field("torque", want.torque, out_chan.torque);
        compare_field("last", want.last, out_chan.last);
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("quadrotor_pd_attitude_mixer_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [qpam_pkg::IN_W-1:0] pick_signal();
    case ($urandom_range(0, 9))
      0:       return SIG_MAX;
      1:       return SIG_MIN;
      2, 3:    return $urandom;
      default: return qpam_pkg::IN_W'($signed(20'($urandom)));  // moderate magnitudes
    endcase
  endfunction

  // Sticks cluster around the deadband edge as well as the extremes
  function automatic logic signed [qpam_pkg::STICK_W-1:0] pick_stick();
    logic signed [qpam_pkg::STICK_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = STICK_MAX;
      1:       v = STICK_MIN;
      2:       v = qpam_pkg::STICK_W'($urandom_range(0, 6000));
      3:       v = qpam_pkg::STICK_W'(deadband_r);
      4:       v = qpam_pkg::STICK_W'(deadband_r) - 16'sd1;
      default: v = qpam_pkg::STICK_W'($urandom);
    endcase
    if (v != STICK_MIN && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic queue_sample(qpam_pkg::axis_e ax,
                              logic signed [qpam_pkg::STICK_W-1:0] stick,
                              logic signed [qpam_pkg::IN_W-1:0] angle,
                              logic signed [qpam_pkg::IN_W-1:0] rate,
                              logic signed [qpam_pkg::IN_W-1:0] vel,
                              logic signed [qpam_pkg::IN_W-1:0] acc);
    axis_sample_t s;
    s.axis    = ax;
    s.stick   = stick;
    s.angle   = angle;
    s.rate    = rate;
    s.lat_vel = vel;
    s.lat_acc = acc;
    pending_q.push_back(s);
    samples_queued++;
  endtask

  task automatic queue_random_sample(qpam_pkg::axis_e ax);
    queue_sample(ax, pick_stick(), pick_signal(), pick_signal(), pick_signal(),
                 pick_signal());
  endtask

  // Mostly complete control ticks (alt, roll, pitch, yaw), some stray axes
  task automatic queue_random_ticks(int count);
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 7) begin
        for (int a = 0; a < qpam_pkg::AXIS_COUNT; a++)
          queue_random_sample(qpam_pkg::axis_e'(a));
        made += qpam_pkg::AXIS_COUNT;
      end else begin
        queue_random_sample(qpam_pkg::axis_e'($urandom_range(0, qpam_pkg::AXIS_COUNT - 1)));
        made++;
      end
    end
  endtask

  // Block until the DUT has taken every sample and returned every command,
  // then let any trailing non-yaw samples clear the sequencer.
  task automatic wait_drained();
    while (samples_accepted != samples_queued || rotor_cmd_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [qpam_pkg::CFG_IDX_W-1:0] idx,
                           logic [qpam_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    cfg_chan.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_chan.ready);
    shadow_reg_write(idx, data);
    cfg_chan.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    reset_shadow();
    rst_ni                        = 1'b0;
    in_chan.valid                 = 1'b0;
    in_chan.axis                  = '0;
    in_chan.stick                 = '0;
    in_chan.angle                 = '0;
    in_chan.rate                  = '0;
    in_chan.lateral_velocity      = '0;
    in_chan.lateral_acceleration  = '0;
    out_chan.ready                = 1'b0;
    cfg_chan.valid                = 1'b0;
    cfg_chan.index                = '0;
    cfg_chan.data                 = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults: stick extremes, deadband edges, saturating sums
    queue_sample(qpam_pkg::AXIS_ALT,   STICK_MAX, '0, '0, $urandom, $urandom);  // lateral ignored
    queue_sample(qpam_pkg::AXIS_ALT,   STICK_MIN, SIG_MAX, SIG_MIN, '0, '0);
    queue_sample(qpam_pkg::AXIS_ALT,   16'sd6553, SIG_MIN, SIG_MAX, SIG_MAX, SIG_MIN);
    queue_sample(qpam_pkg::AXIS_ROLL,  16'sd6554, SIG_MIN, '0, SIG_MAX, SIG_MAX);
    queue_sample(qpam_pkg::AXIS_ROLL,  STICK_MIN, SIG_MAX, SIG_MIN, SIG_MIN, SIG_MIN);
    queue_sample(qpam_pkg::AXIS_PITCH, STICK_MAX, $urandom, $urandom, $urandom, $urandom);
    queue_sample(qpam_pkg::AXIS_PITCH, -16'sd6553, '0, SIG_MAX, '0, '0);
    // yaw: angle and lateral fields are don't-cares; rate steps saturate d/dt
    queue_sample(qpam_pkg::AXIS_YAW,   STICK_MAX, $urandom, SIG_MAX, $urandom, $urandom);
    queue_sample(qpam_pkg::AXIS_YAW,   STICK_MIN, $urandom, SIG_MIN, $urandom, $urandom);
    queue_sample(qpam_pkg::AXIS_YAW,   '0, '0, '0, '0, '0);
    // an ordinary tick with small signals
    queue_sample(qpam_pkg::AXIS_ALT,   16'sd12000, 32'sd65536, -32'sd3000, '0, '0);
    queue_sample(qpam_pkg::AXIS_ROLL,  -16'sd9000, 32'sd2000, 32'sd500, -32'sd40000,
                 32'sd1000);
    queue_sample(qpam_pkg::AXIS_PITCH, 16'sd20000, -32'sd7000, -32'sd800, 32'sd30000,
                 -32'sd2500);
    queue_sample(qpam_pkg::AXIS_YAW,   -16'sd6554, '0, 32'sd123, '0, '0);
    queue_sample(qpam_pkg::AXIS_YAW,   16'sd15000, '0, -32'sd4000, '0, '0);
    wait_drained();

    // Upper extremes; the start altitude write also reloads the target
    write_reg(qpam_pkg::CFG_HOVER,     32'hFFFF_FFFF);
    write_reg(qpam_pkg::CFG_STEP,      32'hFFFF_FFFF);
    write_reg(qpam_pkg::CFG_INV_STEP,  32'hFFFF_FFFF);
    write_reg(qpam_pkg::CFG_DEADBAND,  32'hFFFF_8000);   // deadband off
    write_reg(qpam_pkg::CFG_START_ALT, 32'h7FFF_FFFF);
    queue_sample(qpam_pkg::AXIS_ALT,   STICK_MIN, SIG_MIN, '0, '0, '0);
    queue_sample(qpam_pkg::AXIS_ROLL,  16'sd1, '0, '0, '0, '0);
    queue_sample(qpam_pkg::AXIS_PITCH, -16'sd1, '0, '0, '0, '0);
    queue_sample(qpam_pkg::AXIS_YAW,   16'sd1, '0, 32'sd1, '0, '0);
    queue_random_ticks(44);
    wait_drained();

    // Lower extremes: zero period registers, full deadband, unmapped slots
    write_reg(qpam_pkg::CFG_HOVER,     32'h0000_0000);
    write_reg(qpam_pkg::CFG_STEP,      32'h0000_0000);
    write_reg(qpam_pkg::CFG_INV_STEP,  32'h0000_0000);
    write_reg(qpam_pkg::CFG_DEADBAND,  32'h0000_7FFF);
    write_reg(qpam_pkg::CFG_START_ALT, 32'h8000_0000);
    write_reg(CFG_IDX_UNMAPPED,        $urandom);
    write_reg(CFG_IDX_TOP,             $urandom);
    queue_random_ticks(44);
    wait_drained();

    // Random mid-range settings
    write_reg(qpam_pkg::CFG_HOVER,     $urandom);
    write_reg(qpam_pkg::CFG_STEP,      $urandom);
    write_reg(qpam_pkg::CFG_INV_STEP,  $urandom_range(1, 32'h0100_0000));
    write_reg(qpam_pkg::CFG_DEADBAND,  $urandom);
    write_reg(qpam_pkg::CFG_START_ALT, $urandom);
    queue_random_ticks(56);
    wait_drained();

    if (failures == 0)
      $display("quadrotor_pd_attitude_mixer_top test passed");
    else
      $display("quadrotor_pd_attitude_mixer_top test failed");
    $finish;
  end

endmodule
